[rtl/lhist_pkg.sv]
// ============================================================================
// lhist_pkg: shared types and helpers for the log2 latency histogram
// Holds the operation codes, the queued request type and the arithmetic
// helpers used by the back end.
// ============================================================================
package lhist_pkg;

   localparam int NUM_BUCKETS_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 2;
   localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
   localparam logic [16:0] Q16_ONE    = 17'h10000;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  bucket;
      logic [63:0] latency;
      logic [16:0] fraction;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REC,
      ST_WALK
   } state_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [32:0] half_midpoint(input logic [6:0] i);
      logic [65:0] w;
      w = 66'(3) << (i - 7'd1);
      if (i == 7'd0) begin
         return 33'd1;
      end
      if (i == 7'd1) begin
         return 33'd2;
      end
      return w[32:0];
   endfunction

endpackage

[rtl/lhist_front.sv]
// ============================================================================
// lhist_front: request classification
// Decodes the operation, computes the clamped bucket of a recorded latency
// and clamps the query fraction before the request enters the queue.
// ============================================================================
module lhist_front #(
   parameter int NUM_BUCKETS = lhist_pkg::NUM_BUCKETS_DEFAULT
) (
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_latency_us,
   input  logic [16:0]        req_fraction_q16,
   output lhist_pkg::item_type item
);

   logic [6:0] bit_len;
   logic [6:0] bucket;

   always_comb begin
      bit_len = 7'd0;
      for (int i = 0; i < 64; i++) begin
         if (req_latency_us[i]) begin
            bit_len = 7'(i + 1);
         end
      end
      if (bit_len > 7'(NUM_BUCKETS - 1)) begin
         bucket = 7'(NUM_BUCKETS - 1);
      end else begin
         bucket = bit_len;
      end
   end

   always_comb begin
      item.op       = lhist_pkg::op_type'(req_operation);
      item.bucket   = bucket;
      item.latency  = req_latency_us;
      item.fraction = (req_fraction_q16 > lhist_pkg::Q16_ONE) ?
                      lhist_pkg::Q16_ONE : req_fraction_q16;
   end

endmodule

[rtl/lhist_queue.sv]
// ============================================================================
// lhist_queue: request queue
// A short register queue that decouples request acceptance from execution.
// ============================================================================
module lhist_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lhist_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output lhist_pkg::item_type head_item,
   output logic                empty
);

   localparam int PW = lhist_pkg::QUEUE_PTR_W;

   lhist_pkg::item_type entries_ff [lhist_pkg::QUEUE_DEPTH];
   logic [PW:0] wr_ptr_ff, wr_ptr_in;
   logic [PW:0] rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) &&
                  (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);
   assign head_item = entries_ff[rd_ptr_ff[PW-1:0]];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entries_ff[wr_ptr_ff[PW-1:0]] <= push_item;
      end
   end

endmodule

[rtl/lhist_back.sv]
// ============================================================================
// lhist_back: histogram execution
// Owns the bucket count memory, the sample count and the latency sum.
// Records do a read-modify-write of one bucket, queries walk the buckets
// one per cycle, and clears drop all bucket valid bits at once.
// ============================================================================
module lhist_back #(
   parameter int NUM_BUCKETS = lhist_pkg::NUM_BUCKETS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lhist_pkg::item_type item,
   input  logic                item_valid,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [32:0]         rsp_percentile_half_us,
   output logic [4:0]          rsp_recorded_bucket,
   output logic [31:0]         rsp_sample_count,
   output logic [63:0]         rsp_latency_sum
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int CW = 32 + BW;
   localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BUCKETS - 1);
   localparam logic [32:0] EXHAUSTED =
      (NUM_BUCKETS <= 32) ? (33'(1) << NUM_BUCKETS) : 33'd0;

   logic [31:0] cnt_mem_ff [NUM_BUCKETS];
   logic [31:0] mem_q_ff;
   logic        vld_q_ff;
   logic [NUM_BUCKETS-1:0] bvalid_ff, bvalid_in;

   lhist_pkg::state_type state_ff, state_in;
   logic [31:0]   total_ff, total_in;
   logic [63:0]   sum_ff, sum_in;
   logic [6:0]    cur_bucket_ff, cur_bucket_in;
   logic [32:0]   target_ff, target_in;
   logic [CW-1:0] cum_ff, cum_in;
   logic [BW-1:0] walk_idx_ff, walk_idx_in;
   logic [BW-1:0] chk_idx_ff, chk_idx_in;
   logic          chk_vld_ff, chk_vld_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [32:0]   rsp_pct_ff, rsp_pct_in;
   logic [4:0]    rsp_bkt_ff, rsp_bkt_in;
   logic [31:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [63:0]   rsp_sum_ff, rsp_sum_in;

   logic [BW-1:0] rd_addr;
   logic          mem_we;
   logic [BW-1:0] mem_wa;
   logic [31:0]   mem_wd;
   logic [31:0]   cur_count;
   logic [CW-1:0] cum_next;
   logic [48:0]   product;
   logic [32:0]   raw_target;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur_count = vld_q_ff ? mem_q_ff : 32'd0;
   assign cum_next  = cum_ff + CW'(cur_count);
   assign product   = 49'(item.fraction) * 49'(total_ff);
   assign raw_target = product[48:16];

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      sum_in        = sum_ff;
      cur_bucket_in = cur_bucket_ff;
      target_in     = target_ff;
      cum_in        = cum_ff;
      walk_idx_in   = walk_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      bvalid_in     = bvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pct_in    = rsp_pct_ff;
      rsp_bkt_in    = rsp_bkt_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_sum_in    = rsp_sum_ff;
      item_pop      = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = cur_bucket_ff[BW-1:0];
      mem_wd        = lhist_pkg::sat_inc(cur_count);
      rd_addr       = cur_bucket_ff[BW-1:0];

      case (state_ff)
         lhist_pkg::ST_IDLE: begin
            rd_addr = item.bucket[BW-1:0];
            if (item_valid && out_free) begin
               item_pop   = 1'b1;
               rsp_pct_in = 33'd0;
               rsp_bkt_in = 5'd0;
               case (item.op)
                  lhist_pkg::OP_RECORD: begin
                     cur_bucket_in = item.bucket;
                     total_in      = lhist_pkg::sat_inc(total_ff);
                     sum_in        = sum_ff + item.latency;
                     state_in      = lhist_pkg::ST_REC;
                  end
                  lhist_pkg::OP_QUERY: begin
                     if (item.fraction == 17'd0 || total_ff == 32'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_cnt_in   = total_ff;
                        rsp_sum_in   = sum_ff;
                     end else begin
                        target_in   = (raw_target == 33'd0) ? 33'd1 : raw_target;
                        cum_in      = '0;
                        walk_idx_in = '0;
                        chk_vld_in  = 1'b0;
                        state_in    = lhist_pkg::ST_WALK;
                     end
                  end
                  lhist_pkg::OP_CLEAR: begin
                     bvalid_in    = '0;
                     total_in     = 32'd0;
                     sum_in       = 64'd0;
                     rsp_valid_in = 1'b1;
                     rsp_cnt_in   = 32'd0;
                     rsp_sum_in   = 64'd0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_cnt_in   = total_ff;
                     rsp_sum_in   = sum_ff;
                  end
               endcase
            end
         end
         lhist_pkg::ST_REC: begin
            mem_we                          = 1'b1;
            bvalid_in[cur_bucket_ff[BW-1:0]] = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_pct_in   = 33'd0;
            rsp_bkt_in   = cur_bucket_ff[4:0];
            rsp_cnt_in   = total_ff;
            rsp_sum_in   = sum_ff;
            state_in     = lhist_pkg::ST_IDLE;
         end
         lhist_pkg::ST_WALK: begin
            rd_addr    = walk_idx_ff;
            chk_vld_in = 1'b1;
            chk_idx_in = walk_idx_ff;
            if (walk_idx_ff != LAST_IDX) begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               cum_in = cum_next;
               if (cum_next >= CW'(target_ff) || chk_idx_ff == LAST_IDX) begin
                  rsp_valid_in = 1'b1;
                  rsp_bkt_in   = 5'd0;
                  rsp_cnt_in   = total_ff;
                  rsp_sum_in   = sum_ff;
                  rsp_pct_in   = (cum_next >= CW'(target_ff)) ?
                                 lhist_pkg::half_midpoint(7'(chk_idx_ff)) : EXHAUSTED;
                  state_in     = lhist_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lhist_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhist_pkg::ST_IDLE;
         total_ff     <= 32'd0;
         sum_ff       <= 64'd0;
         bvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         bvalid_ff    <= bvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bucket_ff <= cur_bucket_in;
      target_ff     <= target_in;
      cum_ff        <= cum_in;
      walk_idx_ff   <= walk_idx_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_bkt_ff    <= rsp_bkt_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem_ff[mem_wa] <= mem_wd;
      end
      mem_q_ff <= cnt_mem_ff[rd_addr];
      vld_q_ff <= bvalid_ff[rd_addr];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_percentile_half_us = rsp_pct_ff;
   assign rsp_recorded_bucket    = rsp_bkt_ff;
   assign rsp_sample_count       = rsp_cnt_ff;
   assign rsp_latency_sum        = rsp_sum_ff;

endmodule

[rtl/latency_log2_histogram_core.sv]
// ============================================================================
// latency_log2_histogram_core: log2 latency histogram with percentile query
// Records latencies into power-of-two buckets, keeps a saturating sample
// count and a wrapping latency sum, answers percentile queries and clears.
// ============================================================================
//
//   Channel   Direction   Handshake               Payload
//   req_      in          req_valid / req_ready   operation, latency, fraction
//   rsp_      out         rsp_valid / rsp_ready   percentile, bucket, count, sum
//
// A record does a read-modify-write in the back end: one bucket read, then write back.
// A clear, an unused operation or a trivial query is answered straight from the idle state.
// A query walks one bucket per cycle through the count memory read port.
// Reset clears the bucket valid bits at once; there is no clearing pass.
// A two-entry queue keeps taking requests, until it is full, while the back end
// or the output register is stalled.
module latency_log2_histogram_core #(
   parameter int NUM_BUCKETS = lhist_pkg::NUM_BUCKETS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_latency_us,
   input  logic [16:0] req_fraction_q16,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [32:0] rsp_percentile_half_us,
   output logic [4:0]  rsp_recorded_bucket,
   output logic [31:0] rsp_sample_count,
   output logic [63:0] rsp_latency_sum
);

   lhist_pkg::item_type front_item;
   lhist_pkg::item_type head_item;
   logic                q_full;
   logic                q_empty;
   logic                q_pop;

   assign req_ready = !q_full;

   lhist_front #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_front (
      .req_operation   (req_operation),
      .req_latency_us  (req_latency_us),
      .req_fraction_q16(req_fraction_q16),
      .item            (front_item)
   );

   lhist_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid),
      .push_item(front_item),
      .full     (q_full),
      .pop      (q_pop),
      .head_item(head_item),
      .empty    (q_empty)
   );

   lhist_back #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .item                  (head_item),
      .item_valid            (!q_empty),
      .item_pop              (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_percentile_half_us(rsp_percentile_half_us),
      .rsp_recorded_bucket   (rsp_recorded_bucket),
      .rsp_sample_count      (rsp_sample_count),
      .rsp_latency_sum       (rsp_latency_sum)
   );

endmodule

[rtl/lhist_checker.sv]
// ============================================================================
// lhist_checker: port-level checks for the latency histogram
// Watches the top-level ports and flags responses that cannot be correct.
// ============================================================================
module lhist_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [32:0] rsp_percentile_half_us,
   input logic [4:0]  rsp_recorded_bucket,
   input logic [31:0] rsp_sample_count,
   input logic [63:0] rsp_latency_sum
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_percentile_half_us) &&
      $stable(rsp_recorded_bucket) && $stable(rsp_sample_count) &&
      $stable(rsp_latency_sum))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_recorded_bucket == 5'd0 || rsp_percentile_half_us == 33'd0)
      else $error("response carries both a bucket and a percentile");

   a_bucket_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recorded_bucket != 5'd0 |-> rsp_sample_count != 32'd0)
      else $error("record response with zero sample count");

   a_pct_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_percentile_half_us != 33'd0 |-> rsp_sample_count != 32'd0)
      else $error("percentile answered on an empty histogram");

endmodule

bind latency_log2_histogram_core lhist_checker u_lhist_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_percentile_half_us(rsp_percentile_half_us),
   .rsp_recorded_bucket   (rsp_recorded_bucket),
   .rsp_sample_count      (rsp_sample_count),
   .rsp_latency_sum       (rsp_latency_sum)
);
